/* rtl/mffd_pkg.sv */
`timescale 1ns / 1ps

package mffd_pkg;

  // Frame and burst geometry
  localparam int FRAME_BYTES = 10;
  localparam int MAX_BURST   = 256;
  localparam int STORE_DEPTH = FRAME_BYTES - 1;
  localparam int BIF_W       = $clog2(FRAME_BYTES);
  localparam int BC_W        = $clog2(MAX_BURST + 1);

  // Frame bytes that map onto result fields (bytes 0..8)
  localparam int FIELD_BYTES = 9;
  localparam int VIEW_BYTES  = (STORE_DEPTH < FIELD_BYTES) ? STORE_DEPTH : FIELD_BYTES;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // CRC-8/MAXIM, reflected
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Power-on burst signature
  localparam logic [7:0] PWR_BYTE0 = 8'hAA;
  localparam logic [7:0] PWR_BYTE1 = 8'h55;
  localparam logic [7:0] PWR_BYTE2 = 8'hFF;
  localparam int         PWR_LEN   = 3;

  typedef enum logic [1:0] {
    KIND_FRAME    = 2'd0,
    KIND_POWER_ON = 2'd1,
    KIND_WHOLE    = 2'd2,
    KIND_BAD_LEN  = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_burst;
  } in_t;

  typedef struct packed {
    kind_t              result_kind;
    logic [7:0]         dev_addr;
    logic [7:0]         mode_byte;
    logic signed [15:0] phase_current;
    logic signed [15:0] rotor_speed;
    logic [15:0]        word_six_seven;
    logic [7:0]         fault_code;
    logic               crc_ok;
    logic [8:0]         burst_length;
    logic [31:0]        power_on_count;
    logic               last_of_run;
  } out_t;

  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/motor_feedback_frame_decoder.sv */
`timescale 1ns / 1ps

// Motor feedback frame decoder.
// Input channel (in_valid / in_stall / in_data): one received byte of an RS485
// reply burst per transaction, with end_of_burst set on the last byte before
// the line goes idle. Bytes are cut into FRAME_BYTES-long frames; each frame
// yields a frame result with its fields and a CRC-8/MAXIM check. The byte
// that ends a burst also yields a summary result (power-on, whole frames or
// bad length). A byte can cause zero, one or two results.
// Output channel (out_valid / out_stall / out_data): one result per
// transaction, in order; last_of_run marks the final result of a byte.
// Latency: with the queue empty, a result caused by a byte is offered on the
// cycle after that byte is accepted; the second result of a byte follows once
// the first is taken. Results queued earlier go out first.
// Throughput: one byte per cycle. The parse state and CRC register each accepted
// byte; results drain through a 4-entry queue, which must keep room for two
// entries to accept a byte, so sustained rate is one byte per cycle while the
// receiver takes one result per cycle.
// Reset (rst_n low, synchronous): clears the CRC, frame position, burst
// count, power-on counter and the result queue.
// Receiver stall: queued results hold; once fewer than two entries are free,
// in_stall rises and the input waits.

module motor_feedback_frame_decoder
  import mffd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Parse state
  logic [7:0]       crc_r, crc_nxt;
  logic [BIF_W-1:0] bif_r, bif_nxt;
  logic [BC_W-1:0]  bc_r, bc_nxt;
  logic [31:0]      pot_r, pot_nxt;
  logic [7:0]       store_r [STORE_DEPTH];
  logic [7:0]       store_nxt [STORE_DEPTH];

  // Result queue
  out_t                  fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  logic       in_acc;
  logic       out_acc;
  logic       frame_hit;
  logic       eob_hit;
  logic [7:0] b;
  logic [7:0] view [FIELD_BYTES];
  logic       pwr_burst;
  kind_t      sum_kind;
  out_t       frame_res;
  out_t       sum_res;
  out_t       res_a;
  out_t       res_b;
  logic [1:0] push_n;

  // Keep room for two results so a frame-ending, burst-ending byte never drops one
  assign in_stall  = (cnt_r > FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = fifo_r[rd_ptr_r];
  assign b         = in_data.rx_byte;

  // Stored frame bytes as seen by the field map; field bytes beyond the stored depth read zero
  always_comb begin
    for (int i = 0; i < FIELD_BYTES; i++) begin
      view[i] = 8'd0;
    end
    for (int i = 0; i < VIEW_BYTES; i++) begin
      view[i] = store_r[i];
    end
  end

  // Parse step for one accepted byte
  always_comb begin
    crc_nxt   = crc_r;
    bif_nxt   = bif_r;
    bc_nxt    = bc_r;
    pot_nxt   = pot_r;
    frame_hit = 1'b0;
    eob_hit   = 1'b0;
    pwr_burst = 1'b0;
    sum_kind  = KIND_BAD_LEN;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_nxt[i] = store_r[i];
    end

    if (in_acc) begin
      // Drop bytes once the burst buffer is full
      if (bc_r < BC_W'(MAX_BURST)) begin
        bc_nxt = bc_r + 1'b1;
        if (bif_r < BIF_W'(STORE_DEPTH)) begin
          for (int i = 0; i < STORE_DEPTH; i++) begin
            if (bif_r == BIF_W'(i)) begin
              store_nxt[i] = b;
            end
          end
          crc_nxt = crc_feed(crc_r, b);
          bif_nxt = bif_r + 1'b1;
        end else begin
          frame_hit = 1'b1;
          crc_nxt   = 8'd0;
          bif_nxt   = '0;
        end
      end

      if (in_data.end_of_burst) begin
        eob_hit   = 1'b1;
        pwr_burst = (bc_nxt == BC_W'(PWR_LEN)) && (bif_nxt == BIF_W'(PWR_LEN)) &&
                    (store_nxt[0] == PWR_BYTE0) && (store_nxt[1] == PWR_BYTE1) &&
                    (store_nxt[2] == PWR_BYTE2);
        if (pwr_burst) begin
          sum_kind = KIND_POWER_ON;
          if (pot_r != 32'hFFFF_FFFF) begin
            pot_nxt = pot_r + 32'd1;
          end
        end else if ((bc_nxt != '0) && (bif_nxt == '0)) begin
          // Frame position tracks the burst count modulo the frame length
          sum_kind = KIND_WHOLE;
        end else begin
          sum_kind = KIND_BAD_LEN;
        end
        // Close the burst
        bc_nxt  = '0;
        bif_nxt = '0;
        crc_nxt = 8'd0;
      end
    end
  end

  // Build the results
  always_comb begin
    frame_res                = '0;
    frame_res.result_kind    = KIND_FRAME;
    frame_res.dev_addr       = view[0];
    frame_res.mode_byte      = view[1];
    frame_res.phase_current  = {view[2], view[3]};
    frame_res.rotor_speed    = {view[4], view[5]};
    frame_res.word_six_seven = {view[6], view[7]};
    frame_res.fault_code     = view[8];
    frame_res.crc_ok         = (crc_r == b);
    frame_res.burst_length   = 9'(bc_r + 1'b1);
    frame_res.power_on_count = pot_r;
    frame_res.last_of_run    = !eob_hit;

    sum_res                = '0;
    sum_res.result_kind    = sum_kind;
    sum_res.burst_length   = 9'(bc_r < BC_W'(MAX_BURST) ? bc_r + 1'b1 : bc_r);
    sum_res.power_on_count = pot_nxt;
    sum_res.last_of_run    = 1'b1;

    if (frame_hit) begin
      res_a = frame_res;
      res_b = sum_res;
    end else begin
      res_a = sum_res;
      res_b = sum_res;
    end
    push_n = {1'b0, frame_hit} + {1'b0, eob_hit};
  end

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_n);
    rd_ptr_nxt = out_acc ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= 8'd0;
      bif_r    <= '0;
      bc_r     <= '0;
      pot_r    <= 32'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      crc_r    <= crc_nxt;
      bif_r    <= bif_nxt;
      bc_r     <= bc_nxt;
      pot_r    <= pot_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      store_r[i] <= store_nxt[i];
    end
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= res_a;
    end
    if (push_n == 2'd2) begin
      fifo_r[FIFO_PTR_W'(wr_ptr_r + 1'b1)] <= res_b;
    end
  end

endmodule
